// ----- rtl/core/lbp_pkg.sv -----
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types, constants and the gamma table for the LED breathing PWM block.
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int NUM_LEDS    = 5;
  localparam int LED_IDX_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int LED_FIELD_W = 3;
  localparam int PIN_W       = 5;
  localparam int INT_W       = 32;
  localparam int SPEED_SHIFT = 8;
  localparam int SPEED_W     = INT_W - SPEED_SHIFT;
  localparam int DUTY_W      = 8;
  localparam int PHASE_W     = 8;
  localparam int INDEX_SHIFT = INT_W - DUTY_W;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;

  // input action codes
  localparam logic [1:0] ACT_PWM  = 2'd0;
  localparam logic [1:0] ACT_RAMP = 2'd1;
  localparam logic [1:0] ACT_LOAD = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  // decoded operations handed to the back end
  localparam logic [1:0] OP_PWM  = 2'd0;
  localparam logic [1:0] OP_RAMP = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;
  localparam logic [1:0] OP_HOLD = 2'd3;

  typedef struct packed {
    logic [1:0]             action;
    logic [LED_FIELD_W-1:0] led;
    logic [INT_W-1:0]       random_word;
    logic [INT_W-1:0]       start_speed_word;
    logic                   start_up;
  } in_beat_t;

  typedef struct packed {
    logic [PIN_W-1:0]  led_pins;
    logic [DUTY_W-1:0] brightness;
    logic              rising;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [LED_IDX_W-1:0] idx;
    logic                 led_ok;
    logic [INT_W-1:0]     word;
    logic [SPEED_W-1:0]   speed;
    logic                 up;
  } cmd_t;

  localparam logic [DUTY_W-1:0] GAMMA_ROM [256] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h03, 8'h03,
    8'h03, 8'h03, 8'h03, 8'h03, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h05, 8'h05, 8'h05,
    8'h05, 8'h06, 8'h06, 8'h06, 8'h07, 8'h07, 8'h07, 8'h08, 8'h08, 8'h08, 8'h09, 8'h09,
    8'h0A, 8'h0A, 8'h0B, 8'h0B, 8'h0C, 8'h0C, 8'h0D, 8'h0D, 8'h0E, 8'h0F, 8'h0F, 8'h10,
    8'h11, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B,
    8'h1C, 8'h1D, 8'h1F, 8'h20, 8'h21, 8'h23, 8'h24, 8'h26, 8'h27, 8'h29, 8'h2B, 8'h2C,
    8'h2E, 8'h30, 8'h32, 8'h34, 8'h36, 8'h38, 8'h3A, 8'h3C, 8'h3E, 8'h40, 8'h43, 8'h45,
    8'h47, 8'h4A, 8'h4C, 8'h4F, 8'h51, 8'h54, 8'h57, 8'h59, 8'h5C, 8'h5F, 8'h62, 8'h64,
    8'h67, 8'h6A, 8'h6D, 8'h70, 8'h73, 8'h76, 8'h79, 8'h7C, 8'h7F, 8'h82, 8'h85, 8'h88,
    8'h8B, 8'h8E, 8'h91, 8'h94, 8'h97, 8'h9A, 8'h9C, 8'h9F, 8'hA2, 8'hA5, 8'hA7, 8'hAA,
    8'hAD, 8'hAF, 8'hB2, 8'hB4, 8'hB7, 8'hB9, 8'hBB, 8'hBE, 8'hC0, 8'hC2, 8'hC4, 8'hC6,
    8'hC8, 8'hCA, 8'hCC, 8'hCE, 8'hD0, 8'hD2, 8'hD3, 8'hD5, 8'hD7, 8'hD8, 8'hDA, 8'hDB,
    8'hDD, 8'hDE, 8'hDF, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7, 8'hE8, 8'hE9,
    8'hEA, 8'hEB, 8'hEC, 8'hED, 8'hED, 8'hEE, 8'hEF, 8'hEF, 8'hF0, 8'hF1, 8'hF1, 8'hF2,
    8'hF2, 8'hF3, 8'hF3, 8'hF4, 8'hF4, 8'hF5, 8'hF5, 8'hF6, 8'hF6, 8'hF6, 8'hF7, 8'hF7,
    8'hF7, 8'hF8, 8'hF8, 8'hF8, 8'hF9, 8'hF9, 8'hF9, 8'hF9, 8'hFA, 8'hFA, 8'hFA, 8'hFA,
    8'hFA, 8'hFB, 8'hFB, 8'hFB, 8'hFB, 8'hFB, 8'hFB, 8'hFC, 8'hFC, 8'hFC, 8'hFC, 8'hFC,
    8'hFC, 8'hFC, 8'hFC, 8'hFC, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD,
    8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFE,
    8'hFE, 8'hFE, 8'hFF, 8'hFF
  };

endpackage

// ----- rtl/core/lbp_front.sv -----
// ----------------------------------------------------------------------------
// lbp_front
// Decodes an input beat into a back-end command and picks the speed source.
// ----------------------------------------------------------------------------
module lbp_front (
  input  lbp_pkg::in_beat_t in_beat,
  output lbp_pkg::cmd_t     cmd
);

  logic led_ok;

  assign led_ok = (32'(in_beat.led) < lbp_pkg::NUM_LEDS);

  always_comb begin
    cmd        = '0;
    cmd.led_ok = led_ok;
    cmd.idx    = led_ok ? lbp_pkg::LED_IDX_W'(in_beat.led) : '0;
    cmd.word   = in_beat.random_word;
    cmd.up     = in_beat.start_up;
    cmd.speed  = in_beat.random_word[lbp_pkg::INT_W-1:lbp_pkg::SPEED_SHIFT];
    unique case (in_beat.action)
      lbp_pkg::ACT_PWM: begin
        cmd.op = lbp_pkg::OP_PWM;
      end
      lbp_pkg::ACT_RAMP: begin
        cmd.op = led_ok ? lbp_pkg::OP_RAMP : lbp_pkg::OP_HOLD;
      end
      lbp_pkg::ACT_LOAD: begin
        cmd.op    = led_ok ? lbp_pkg::OP_LOAD : lbp_pkg::OP_HOLD;
        cmd.speed = in_beat.start_speed_word[lbp_pkg::INT_W-1:lbp_pkg::SPEED_SHIFT];
      end
      default: begin
        cmd.op = lbp_pkg::OP_HOLD;
      end
    endcase
  end

endmodule

// ----- rtl/core/lbp_queue.sv -----
// ----------------------------------------------------------------------------
// lbp_queue
// Two-entry command queue between the decoder and the execution stage.
// ----------------------------------------------------------------------------
module lbp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lbp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output lbp_pkg::cmd_t head_cmd
);

  lbp_pkg::cmd_t                entry_r [lbp_pkg::Q_DEPTH];
  logic [lbp_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [lbp_pkg::Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [lbp_pkg::Q_CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full       = (32'(cnt_r) == lbp_pkg::Q_DEPTH);
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/core/lbp_back.sv -----
// ----------------------------------------------------------------------------
// lbp_back
// Per-LED ramp state, gamma lookup, PWM phase and the registered result beat.
// ----------------------------------------------------------------------------
module lbp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  lbp_pkg::cmd_t      head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output lbp_pkg::out_beat_t out_data
);

  logic [lbp_pkg::INT_W-1:0]   intensity_r  [lbp_pkg::NUM_LEDS];
  logic [lbp_pkg::INT_W-1:0]   intensity_nxt[lbp_pkg::NUM_LEDS];
  logic [lbp_pkg::SPEED_W-1:0] speed_r      [lbp_pkg::NUM_LEDS];
  logic [lbp_pkg::SPEED_W-1:0] speed_nxt    [lbp_pkg::NUM_LEDS];
  logic [lbp_pkg::DUTY_W-1:0]  duty_r       [lbp_pkg::NUM_LEDS];
  logic [lbp_pkg::DUTY_W-1:0]  duty_nxt     [lbp_pkg::NUM_LEDS];
  logic [lbp_pkg::NUM_LEDS-1:0] up_r, up_nxt;
  logic [lbp_pkg::NUM_LEDS-1:0] pins_r, pins_nxt;
  logic [lbp_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic                         out_valid_r, out_valid_nxt;
  lbp_pkg::out_beat_t           out_data_r, result;

  logic [lbp_pkg::INT_W-1:0]   cur_int, new_int;
  logic [lbp_pkg::SPEED_W-1:0] cur_speed;
  logic                        cur_up, flip;
  logic [lbp_pkg::INT_W:0]     sum, diff;

  assign pop       = head_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cur_int   = intensity_r[head_cmd.idx];
  assign cur_speed = speed_r[head_cmd.idx];
  assign cur_up    = up_r[head_cmd.idx];
  assign sum       = {1'b0, cur_int} + (lbp_pkg::INT_W+1)'(cur_speed);
  assign diff      = {1'b0, cur_int} - (lbp_pkg::INT_W+1)'(cur_speed);

  always_comb begin
    flip    = 1'b0;
    new_int = '0;
    if (cur_up) begin
      flip    = sum[lbp_pkg::INT_W];
      new_int = flip ? '1 : sum[lbp_pkg::INT_W-1:0];
    end else begin
      flip    = diff[lbp_pkg::INT_W];
      new_int = flip ? '0 : diff[lbp_pkg::INT_W-1:0];
    end
  end

  always_comb begin
    intensity_nxt = intensity_r;
    speed_nxt     = speed_r;
    duty_nxt      = duty_r;
    up_nxt        = up_r;
    pins_nxt      = pins_r;
    phase_nxt     = phase_r;
    if (pop) begin
      case (head_cmd.op)
        lbp_pkg::OP_PWM: begin
          for (int i = 0; i < lbp_pkg::NUM_LEDS; i++) begin
            pins_nxt[i] = (phase_r < duty_r[i]);
          end
          phase_nxt = phase_r + 1'b1;
        end
        lbp_pkg::OP_RAMP: begin
          intensity_nxt[head_cmd.idx] = new_int;
          duty_nxt[head_cmd.idx] =
            lbp_pkg::GAMMA_ROM[new_int[lbp_pkg::INT_W-1:lbp_pkg::INDEX_SHIFT]];
          if (flip) begin
            up_nxt[head_cmd.idx]    = !cur_up;
            speed_nxt[head_cmd.idx] = head_cmd.speed;
          end
        end
        lbp_pkg::OP_LOAD: begin
          intensity_nxt[head_cmd.idx] = head_cmd.word;
          up_nxt[head_cmd.idx]        = head_cmd.up;
          speed_nxt[head_cmd.idx]     = head_cmd.speed;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result            = '0;
    result.led_pins   = lbp_pkg::PIN_W'(pins_nxt);
    result.brightness = head_cmd.led_ok ? duty_nxt[head_cmd.idx] : '0;
    result.rising     = head_cmd.led_ok ? up_nxt[head_cmd.idx] : 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lbp_pkg::NUM_LEDS; i++) begin
        intensity_r[i] <= '0;
        speed_r[i]     <= '0;
        duty_r[i]      <= '0;
      end
      up_r        <= '0;
      pins_r      <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      intensity_r <= intensity_nxt;
      speed_r     <= speed_nxt;
      duty_r      <= duty_nxt;
      up_r        <= up_nxt;
      pins_r      <= pins_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= result;
    end
  end

endmodule

// ----- rtl/core/led_breathing_pwm.sv -----
// ----------------------------------------------------------------------------
// led_breathing_pwm
// Breathing LED controller: each LED's 32-bit intensity ramps up and down by
// its own speed, clamps and reverses at the ends with a fresh speed taken from
// the supplied random word, and maps its top byte through a gamma table to an
// 8-bit duty; a shared phase drives software PWM on all pins. One beat is
// taken per clock cycle while the queue is not full, giving one result beat.
// A decoder feeds a two-entry queue; the execution stage retires one command
// per cycle into an output register unless the output stalls (ramp add/clamp
// and gamma lookup are combinational), so a result passes through a queue
// entry and the output register. The input stalls only when the queue is full.
// ----------------------------------------------------------------------------
module led_breathing_pwm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lbp_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lbp_pkg::out_beat_t out_data
);

  lbp_pkg::cmd_t dec_cmd, head_cmd;
  logic          q_full, q_head_valid, q_pop, q_push;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  lbp_front u_front (
    .in_beat (in_data),
    .cmd     (dec_cmd)
  );

  lbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (dec_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (head_cmd)
  );

  lbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- rtl/core/lbp_checker.sv -----
// ----------------------------------------------------------------------------
// lbp_checker
// Port-level checks of the LED breathing PWM block, bound to the top level.
// ----------------------------------------------------------------------------
module lbp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input lbp_pkg::out_beat_t out_data
);

  logic [2:0] pend_r, pend_nxt;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r + 3'(in_fire) - 3'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // results never outrun accepted beats
  a_no_orphan_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 3'd0))
    else $error("result beat with no accepted input beat");

  // queue plus output register bound the beats in flight
  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd3)
    else $error("too many beats in flight");

  // a full pipe must push back on the input
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 3'd3) && !out_fire |-> in_stall)
    else $error("input accepted with no room");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind led_breathing_pwm lbp_checker u_lbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LED breathing PWM block. Directed steps from a
// table, then about 500 random beats (ramps, loads, PWM runs and noise), with
// sender bursts and receiver stalls. Every result beat is compared field by
// field with a typed table entry or the bench model of ramp, gamma map, PWM.
// ----------------------------------------------------------------------------
module tb;

  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_BEATS = 500;
  localparam int HAND_STEPS = 23;

  localparam logic [7:0] GAMMA_CURVE [256] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h03, 8'h03,
    8'h03, 8'h03, 8'h03, 8'h03, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h05, 8'h05, 8'h05,
    8'h05, 8'h06, 8'h06, 8'h06, 8'h07, 8'h07, 8'h07, 8'h08, 8'h08, 8'h08, 8'h09, 8'h09,
    8'h0A, 8'h0A, 8'h0B, 8'h0B, 8'h0C, 8'h0C, 8'h0D, 8'h0D, 8'h0E, 8'h0F, 8'h0F, 8'h10,
    8'h11, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B,
    8'h1C, 8'h1D, 8'h1F, 8'h20, 8'h21, 8'h23, 8'h24, 8'h26, 8'h27, 8'h29, 8'h2B, 8'h2C,
    8'h2E, 8'h30, 8'h32, 8'h34, 8'h36, 8'h38, 8'h3A, 8'h3C, 8'h3E, 8'h40, 8'h43, 8'h45,
    8'h47, 8'h4A, 8'h4C, 8'h4F, 8'h51, 8'h54, 8'h57, 8'h59, 8'h5C, 8'h5F, 8'h62, 8'h64,
    8'h67, 8'h6A, 8'h6D, 8'h70, 8'h73, 8'h76, 8'h79, 8'h7C, 8'h7F, 8'h82, 8'h85, 8'h88,
    8'h8B, 8'h8E, 8'h91, 8'h94, 8'h97, 8'h9A, 8'h9C, 8'h9F, 8'hA2, 8'hA5, 8'hA7, 8'hAA,
    8'hAD, 8'hAF, 8'hB2, 8'hB4, 8'hB7, 8'hB9, 8'hBB, 8'hBE, 8'hC0, 8'hC2, 8'hC4, 8'hC6,
    8'hC8, 8'hCA, 8'hCC, 8'hCE, 8'hD0, 8'hD2, 8'hD3, 8'hD5, 8'hD7, 8'hD8, 8'hDA, 8'hDB,
    8'hDD, 8'hDE, 8'hDF, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7, 8'hE8, 8'hE9,
    8'hEA, 8'hEB, 8'hEC, 8'hED, 8'hED, 8'hEE, 8'hEF, 8'hEF, 8'hF0, 8'hF1, 8'hF1, 8'hF2,
    8'hF2, 8'hF3, 8'hF3, 8'hF4, 8'hF4, 8'hF5, 8'hF5, 8'hF6, 8'hF6, 8'hF6, 8'hF7, 8'hF7,
    8'hF7, 8'hF8, 8'hF8, 8'hF8, 8'hF9, 8'hF9, 8'hF9, 8'hF9, 8'hFA, 8'hFA, 8'hFA, 8'hFA,
    8'hFA, 8'hFB, 8'hFB, 8'hFB, 8'hFB, 8'hFB, 8'hFB, 8'hFC, 8'hFC, 8'hFC, 8'hFC, 8'hFC,
    8'hFC, 8'hFC, 8'hFC, 8'hFC, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD,
    8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFE,
    8'hFE, 8'hFE, 8'hFF, 8'hFF
  };

  typedef struct packed {
    lbp_pkg::in_beat_t  beat;
    logic               typed;
    lbp_pkg::out_beat_t want;
  } hand_step_t;

  // fields: {action, led, random_word, start_speed_word, start_up}, typed, {pins, bright, up}
  localparam hand_step_t HAND_PLAN [HAND_STEPS] = '{
    '{'{lbp_pkg::ACT_PWM,  3'd0, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_NONE, 3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b1, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_RAMP, 3'd7, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1}, 1'b1, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_LOAD, 3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b1, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_LOAD, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b1, '{5'd0, 8'h00, 1'b1}},
    '{'{lbp_pkg::ACT_RAMP, 3'd0, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, '{5'd0, 8'hFF, 1'b0}},
    '{'{lbp_pkg::ACT_RAMP, 3'd0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0}, 1'b0, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_LOAD, 3'd1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0}, 1'b1, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_RAMP, 3'd1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0}, 1'b1, '{5'd0, 8'h00, 1'b1}},
    '{'{lbp_pkg::ACT_RAMP, 3'd1, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_LOAD, 3'd2, 32'h0001_0000, 32'h0100_0000, 1'b0}, 1'b0, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_RAMP, 3'd2, 32'h1234_5678, 32'h0000_0000, 1'b0}, 1'b0, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_LOAD, 3'd3, 32'hFFFF_FFFE, 32'h0000_0100, 1'b1}, 1'b0, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_RAMP, 3'd3, 32'h8765_4321, 32'h0000_0000, 1'b0}, 1'b0, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_LOAD, 3'd4, 32'h8000_0000, 32'hAAAA_AAAA, 1'b1}, 1'b0, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_RAMP, 3'd4, 32'h5555_5555, 32'h5555_5555, 1'b1}, 1'b0, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_PWM,  3'd0, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_PWM,  3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b0, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_PWM,  3'd6, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_NONE, 3'd2, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_RAMP, 3'd3, 32'h0000_0100, 32'h0000_0000, 1'b0}, 1'b0, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_PWM,  3'd1, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, '{5'd0, 8'h00, 1'b0}},
    '{'{lbp_pkg::ACT_NONE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b0, '{5'd0, 8'h00, 1'b0}}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  lbp_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  lbp_pkg::out_beat_t out_data;

  // in-bench copy of the block state
  logic [31:0] lamp_level [lbp_pkg::NUM_LEDS];
  logic [23:0] lamp_speed [lbp_pkg::NUM_LEDS];
  logic        lamp_up [lbp_pkg::NUM_LEDS];
  logic [7:0]  lamp_duty [lbp_pkg::NUM_LEDS];
  logic [7:0]  pwm_phase;
  logic [4:0]  pin_state;

  lbp_pkg::out_beat_t led_results_due [$];
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  int                 burst_left = 0;
  int                 stall_mode = 0;
  int                 stall_timer = 0;

  led_breathing_pwm dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function automatic lbp_pkg::out_beat_t breathe_step(lbp_pkg::in_beat_t b);
    lbp_pkg::out_beat_t r;
    logic [32:0]        sum;
    logic [31:0]        v;
    logic [23:0]        s;
    logic               flip;
    logic               ok;
    int                 n;
    n = int'(b.led);
    ok = (n < lbp_pkg::NUM_LEDS);
    case (b.action)
      lbp_pkg::ACT_PWM: begin
        for (int i = 0; i < lbp_pkg::NUM_LEDS; i++) pin_state[i] = (pwm_phase < lamp_duty[i]);
        pwm_phase = pwm_phase + 8'd1;
      end
      lbp_pkg::ACT_RAMP: if (ok) begin
        v = lamp_level[n];
        s = lamp_speed[n];
        flip = 1'b0;
        if (lamp_up[n]) begin
          sum = {1'b0, v} + {9'd0, s};
          if (sum[32]) begin
            v = 32'hFFFF_FFFF;
            flip = 1'b1;
          end else begin
            v = sum[31:0];
          end
        end else if (v < {8'd0, s}) begin
          v = 32'd0;
          flip = 1'b1;
        end else begin
          v = v - {8'd0, s};
        end
        if (flip) begin
          lamp_up[n] = ~lamp_up[n];
          lamp_speed[n] = b.random_word[31:8];
        end
        lamp_level[n] = v;
        lamp_duty[n] = GAMMA_CURVE[v[31:24]];
      end
      lbp_pkg::ACT_LOAD: if (ok) begin
        lamp_level[n] = b.random_word;
        lamp_up[n] = b.start_up;
        lamp_speed[n] = b.start_speed_word[31:8];
      end
      default: ;
    endcase
    r.led_pins = pin_state;
    r.brightness = ok ? lamp_duty[n] : 8'd0;
    r.rising = ok ? lamp_up[n] : 1'b0;
    return r;
  endfunction

  task automatic send_beat(input lbp_pkg::in_beat_t b, input logic typed,
                           input lbp_pkg::out_beat_t want);
    int                 gap;
    lbp_pkg::out_beat_t got;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 30);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = breathe_step(b);
    led_results_due.push_back(typed ? want : got);
  endtask

  function automatic lbp_pkg::in_beat_t live_beat(int pick);
    lbp_pkg::in_beat_t b;
    logic [23:0]       s;
    int                m;
    b.action = lbp_pkg::ACT_PWM;
    b.led = 3'($urandom_range(0, lbp_pkg::NUM_LEDS - 1));
    b.random_word = $urandom;
    b.start_speed_word = $urandom;
    b.start_up = 1'($urandom_range(0, 1));
    if (pick < 45) begin
      b.action = lbp_pkg::ACT_RAMP;
    end else if (pick < 60) begin
      b.led = 3'($urandom_range(0, 7));
    end else begin
      b.action = lbp_pkg::ACT_LOAD;
      case ($urandom_range(0, 3))
        0: ;
        1: b.random_word = 32'hFFFF_FFFF - $urandom_range(0, 32'h00FF_FFFF);
        2: b.random_word = $urandom_range(0, 32'h00FF_FFFF);
        default: begin
          // falling ramp that lands exactly on zero
          s = 24'($urandom_range(1, 24'hFF_FFFF));
          m = $urandom_range(1, 4);
          b.start_speed_word = {s, 8'($urandom)};
          b.random_word = 32'(s) * 32'(m);
          b.start_up = 1'b0;
        end
      endcase
    end
    return b;
  endfunction

  function automatic lbp_pkg::in_beat_t noise_beat();
    lbp_pkg::in_beat_t b;
    b.random_word = $urandom;
    b.start_speed_word = $urandom;
    b.start_up = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 1) == 0) begin
      b.action = lbp_pkg::ACT_NONE;
      b.led = 3'($urandom_range(0, 7));
    end else begin
      b.action = ($urandom_range(0, 1) == 0) ? lbp_pkg::ACT_RAMP : lbp_pkg::ACT_LOAD;
      b.led = 3'($urandom_range(lbp_pkg::NUM_LEDS, 7));
    end
    return b;
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_timer <= $urandom_range(20, 80);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ($urandom_range(0, 99) < 70);
      default: out_stall <= stall_timer[2];
    endcase
  end

  always @(posedge clk) begin : result_check
    lbp_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (led_results_due.size() == 0) begin
        $display("%0t: result beat with nothing expected: %h", $time, out_data);
        mismatches++;
      end else begin
        want = led_results_due.pop_front();
        if (out_data.led_pins !== want.led_pins) begin
          $display("%0t: led_pins expected %h got %h", $time, want.led_pins,
                   out_data.led_pins);
          mismatches++;
        end
        if (out_data.brightness !== want.brightness) begin
          $display("%0t: brightness expected %h got %h", $time, want.brightness,
                   out_data.brightness);
          mismatches++;
        end
        if (out_data.rising !== want.rising) begin
          $display("%0t: rising expected %b got %b", $time, want.rising,
                   out_data.rising);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[led_breathing_pwm] ERROR");
        $finish;
      end
    end
  end

  initial begin
    lbp_pkg::in_beat_t b;
    int                sent;
    int                pick;
    for (int i = 0; i < lbp_pkg::NUM_LEDS; i++) begin
      lamp_level[i] = '0;
      lamp_speed[i] = '0;
      lamp_up[i] = 1'b0;
      lamp_duty[i] = '0;
    end
    pwm_phase = '0;
    pin_state = '0;
    sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < HAND_STEPS; i++) begin
      send_beat(HAND_PLAN[i].beat, HAND_PLAN[i].typed, HAND_PLAN[i].want);
    end

    while (sent < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // long pwm run to advance the phase
        repeat ($urandom_range(16, 64)) begin
          b = live_beat(50);
          send_beat(b, 1'b0, '0);
          sent++;
        end
      end else if (pick < 85) begin
        send_beat(live_beat(pick), 1'b0, '0);
        sent++;
      end else begin
        send_beat(noise_beat(), 1'b0, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (led_results_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("[led_breathing_pwm] OK");
    end else begin
      $display("[led_breathing_pwm] ERROR");
    end
    $finish;
  end

endmodule
